>>> design/frp_pkg.sv
// shared constants and types of the ftp reply parser
package frp_pkg;

   localparam int unsigned CodeLen = 3;

   localparam logic [7:0] CharDash    = 8'h2d;
   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;

   localparam int unsigned ClassWidth  = 4;
   localparam int unsigned NumberWidth = 10;
   localparam int unsigned DataWidth   = 16;

   typedef struct packed {
      logic                   valid;
      logic [ClassWidth-1:0]  reply_class;
      logic [NumberWidth-1:0] reply_number;
      logic                   bad_code;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

endpackage

>>> design/frp_parse.sv
// reply state machine: code capture, line matching and result generation
module frp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         byte_in,
   output frp_pkg::result_type result
);
   import frp_pkg::*;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_SINGLE = 2'd1,
      PH_MULTI  = 2'd2,
      PH_LSTART = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] index_ff, index_in;
   logic [7:0] code_ff [CodeLen];
   logic       capture;
   logic       code_ok;
   logic       code_hit;
   logic [3:0] d0, d1, d2;
   logic [NumberWidth-1:0] number;

   assign code_ok = is_digit(code_ff[0]) && is_digit(code_ff[1]) && is_digit(code_ff[2]);
   // index 3 means all code characters are in
   assign code_hit = (index_ff != 2'd3) && (code_ff[index_ff] == byte_in);

   assign d0 = code_ff[0][3:0];
   assign d1 = code_ff[1][3:0];
   assign d2 = code_ff[2][3:0];
   assign number = NumberWidth'(d0) * NumberWidth'(100) + NumberWidth'(d1) * NumberWidth'(10)
                   + NumberWidth'(d2);

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      capture  = 1'b0;
      result   = '0;
      case (phase_ff)
         PH_START: begin
            if (index_ff != 2'd3) begin
               capture  = 1'b1;
               index_in = index_ff + 2'd1;
            end else if (code_ok) begin
               phase_in = (byte_in == CharDash) ? PH_MULTI : PH_SINGLE;
            end else begin
               index_in        = 2'd0;
               result.valid    = 1'b1;
               result.bad_code = 1'b1;
            end
         end
         PH_SINGLE: begin
            if (byte_in == CharNewline) begin
               phase_in            = PH_START;
               index_in            = 2'd0;
               result.valid        = 1'b1;
               result.reply_class  = d0;
               result.reply_number = number;
            end
         end
         PH_MULTI: begin
            if (byte_in == CharNewline) begin
               phase_in = PH_LSTART;
               index_in = 2'd0;
            end
         end
         PH_LSTART: begin
            if (index_ff != 2'd3) begin
               if (code_hit) index_in = index_ff + 2'd1;
               else          phase_in = PH_MULTI;
            end else begin
               phase_in = (byte_in == CharSpace) ? PH_SINGLE : PH_MULTI;
            end
         end
         default: phase_in = PH_START;
      endcase
      if (!step_en) result.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         index_ff <= 2'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         if (capture) code_ff[index_ff] <= byte_in;
      end
   end

endmodule

>>> design/ftp_reply_parser_core.sv
// ftp reply parser top level: input register, parser, result register
//
//   channel | direction | tdata                                    | tuser
//   req     | in        | [7:0] byte_in                            | -
//   rsp     | out       | [3:0] reply_class, [13:4] reply_number   | [0] bad_code
//
// one request per cycle sustained while rsp is not stalled; a byte is held in the input
// register and its result, if any, is then registered in the result register.
// reset clears the parse phase, the code index and both valid flags.
// a stalled rsp holds the pipe; req_tready stays high while the result
// register is free or being taken.
module ftp_reply_parser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] byte_in
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [frp_pkg::DataWidth-1:0] rsp_tdata,  // [3:0] reply_class, [13:4] reply_number
   output logic                         rsp_tuser    // [0] bad_code
);
   import frp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [ClassWidth-1:0]  out_class_ff;
   logic [NumberWidth-1:0] out_number_ff;
   logic       out_bad_ff;
   logic       advance;
   logic       out_free;
   result_type result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? result.valid : (out_valid_ff && !rsp_tready);

   frp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .byte_in (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata;
      if (advance && result.valid) begin
         out_class_ff  <= result.reply_class;
         out_number_ff <= result.reply_number;
         out_bad_ff    <= result.bad_code;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_number_ff, out_class_ff};
   assign rsp_tuser  = out_bad_ff;

endmodule
